>>> rtl/impq_pkg.sv
package impq_pkg;

  localparam int CAPACITY  = 64;
  localparam int SLOT_BITS = $clog2(CAPACITY);
  localparam int COUNT_BITS = SLOT_BITS + 1;
  localparam int ID_BITS   = 8;
  localparam int PRIO_BITS = 8;
  localparam int SEQ_BITS  = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_ENQUEUE = 2'd0;
  localparam op_t OP_DEQUEUE = 2'd1;
  localparam op_t OP_CHANGE  = 2'd2;
  localparam op_t OP_REMOVE  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_DUPLICATE = 3'd4;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [SEQ_BITS-1:0]  seq;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ_TOP,
    S_READ_LAST,
    S_PLACE,
    S_UP_READ,
    S_UP_CMP,
    S_DN_READ_L,
    S_DN_READ_R,
    S_DN_CMP,
    S_DONE
  } state_t;

  function automatic logic ranks_before(input slot_t a, input slot_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.seq < b.seq;
  endfunction

endpackage

>>> rtl/indexed_max_priority_queue_core.sv
// Indexed max priority queue: binary max-heap in a slot RAM plus an id-to-slot RAM.
// Sift up works per level by reading the parent, then compare/swap; sift down
// per level reads left, reads right, then compare/swap. One request at a time:
// the next request is taken the cycle after the result is taken.
// Reset (rst, synchronous): empty queue, id present bits cleared, arrival counter zero.
module indexed_max_priority_queue_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] entry_id,
  input  logic [7:0] new_priority,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] out_id,
  output logic [7:0] out_priority
);

  localparam int SB = impq_pkg::SLOT_BITS;
  localparam int CB = impq_pkg::COUNT_BITS;
  localparam int IB = impq_pkg::ID_BITS;

  impq_pkg::slot_t           heap_mem [impq_pkg::CAPACITY];
  logic [SB-1:0]             map_mem  [1 << IB];
  logic [(1 << IB)-1:0]      present;

  impq_pkg::state_t state, state_next;

  impq_pkg::op_t     op;
  logic [IB-1:0]     rid;
  logic [7:0]        rprio;
  logic [CB-1:0]     count;
  logic [31:0]       arrival;
  logic [SB-1:0]     pos;
  impq_pkg::slot_t   cur;
  impq_pkg::slot_t   lft;
  impq_pkg::slot_t   rd_data;
  logic [SB-1:0]     map_rd;
  logic              res_pending;
  impq_pkg::status_t res_status;
  logic [7:0]        res_id, res_prio;
  logic              did_up;

  // memory ports
  logic              h_we;
  logic [SB-1:0]     h_wa, h_ra;
  impq_pkg::slot_t   h_wd;
  logic              h_we2;
  logic [SB-1:0]     h_wa2;
  impq_pkg::slot_t   h_wd2;
  logic              m_we, m_we2;
  logic [IB-1:0]     m_wa, m_wa2;
  logic [SB-1:0]     m_wd, m_wd2;

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    if (h_we2) heap_mem[h_wa2] <= h_wd2;
    rd_data <= heap_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (m_we) map_mem[m_wa] <= m_wd;
    if (m_we2) map_mem[m_wa2] <= m_wd2;
    map_rd <= map_mem[entry_id];
  end

  logic [SB-1:0] parent, lchild, rchild;
  logic [CB-1:0] lchild_w, rchild_w;
  logic          known;
  logic          accept;
  logic          res_fire;

  assign parent   = SB'((pos - 1'b1) >> 1);
  assign lchild_w = CB'({pos, 1'b1});
  assign rchild_w = lchild_w + 1'b1;
  assign lchild   = lchild_w[SB-1:0];
  assign rchild   = rchild_w[SB-1:0];
  assign known    = present[rid];
  assign accept   = in_valid && !in_stall;
  assign res_fire = out_valid && !out_stall;

  assign in_stall     = (state != impq_pkg::S_IDLE) || res_pending;
  assign out_valid    = res_pending;
  assign status       = res_status;
  assign out_id       = res_id;
  assign out_priority = res_prio;

  // best of cur and children for sift down
  logic          l_ok, r_ok, pick_l, pick_r;
  impq_pkg::slot_t best_lr;
  assign l_ok   = lchild_w < count;
  assign r_ok   = rchild_w < count;
  assign pick_l = l_ok && impq_pkg::ranks_before(lft, cur);
  assign best_lr = pick_l ? lft : cur;
  assign pick_r = r_ok && impq_pkg::ranks_before(rd_data, best_lr);

  always_comb begin
    state_next = state;
    unique case (state)
      impq_pkg::S_IDLE:      if (accept) state_next = impq_pkg::S_LOOKUP;
      impq_pkg::S_LOOKUP: begin
        unique case (op)
          impq_pkg::OP_ENQUEUE:
            state_next = (known || count == CB'(impq_pkg::CAPACITY)) ?
                         impq_pkg::S_DONE : impq_pkg::S_UP_READ;
          impq_pkg::OP_DEQUEUE:
            state_next = (count == '0) ? impq_pkg::S_DONE : impq_pkg::S_READ_TOP;
          default:
            state_next = known ? impq_pkg::S_READ_TOP : impq_pkg::S_DONE;
        endcase
      end
      impq_pkg::S_READ_TOP:  state_next = impq_pkg::S_READ_LAST;
      impq_pkg::S_READ_LAST: state_next = impq_pkg::S_PLACE;
      impq_pkg::S_PLACE:     state_next = (op != impq_pkg::OP_CHANGE &&
                                          CB'(pos) >= count) ?
                                          impq_pkg::S_DONE : impq_pkg::S_UP_READ;
      impq_pkg::S_UP_READ:   state_next = (pos == '0) ? impq_pkg::S_DN_READ_L :
                                          impq_pkg::S_UP_CMP;
      impq_pkg::S_UP_CMP:    state_next = impq_pkg::ranks_before(cur, rd_data) ?
                                          impq_pkg::S_UP_READ :
                                          (did_up || op == impq_pkg::OP_ENQUEUE) ?
                                          impq_pkg::S_DONE : impq_pkg::S_DN_READ_L;
      impq_pkg::S_DN_READ_L: state_next = l_ok ? impq_pkg::S_DN_READ_R : impq_pkg::S_DONE;
      impq_pkg::S_DN_READ_R: state_next = impq_pkg::S_DN_CMP;
      impq_pkg::S_DN_CMP:    state_next = (pick_l || pick_r) ? impq_pkg::S_DN_READ_L :
                                          impq_pkg::S_DONE;
      impq_pkg::S_DONE:      state_next = impq_pkg::S_IDLE;
      default:               state_next = impq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    h_we = 1'b0; h_wa = pos; h_wd = cur; h_ra = pos;
    h_we2 = 1'b0; h_wa2 = pos; h_wd2 = cur;
    m_we = 1'b0; m_wa = cur.id; m_wd = pos;
    m_we2 = 1'b0; m_wa2 = rd_data.id; m_wd2 = pos;
    unique case (state)
      impq_pkg::S_LOOKUP: h_ra = (op == impq_pkg::OP_DEQUEUE) ? '0 : map_rd;
      impq_pkg::S_READ_TOP: h_ra = SB'(count - 1'b1);
      impq_pkg::S_UP_READ: h_ra = parent;
      impq_pkg::S_UP_CMP: begin
        if (impq_pkg::ranks_before(cur, rd_data)) begin
          h_we = 1'b1; h_wa = pos; h_wd = rd_data;
          m_we2 = 1'b1; m_wa2 = rd_data.id; m_wd2 = pos;
        end else begin
          h_we = 1'b1; h_wa = pos; h_wd = cur;
          m_we = 1'b1; m_wa = cur.id; m_wd = pos;
        end
      end
      impq_pkg::S_DN_READ_L: begin
        h_ra = lchild;
        if (!l_ok) begin
          h_we = 1'b1; h_wa = pos; h_wd = cur;
          m_we = 1'b1; m_wa = cur.id; m_wd = pos;
        end
      end
      impq_pkg::S_DN_READ_R: h_ra = rchild;
      impq_pkg::S_DN_CMP: begin
        h_we = 1'b1; h_wa = pos;
        m_we2 = 1'b1; m_wa2 = pick_r ? rd_data.id : lft.id; m_wd2 = pos;
        if (pick_r) h_wd = rd_data;
        else if (pick_l) h_wd = lft;
        else begin
          h_wd = cur; m_we2 = 1'b0;
          m_we = 1'b1; m_wa = cur.id; m_wd = pos;
        end
        if (pick_l || pick_r) begin
          h_we2 = 1'b1; h_wa2 = pick_r ? rchild : lchild; h_wd2 = cur;
          m_we = 1'b1; m_wa = cur.id; m_wd = pick_r ? rchild : lchild;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= impq_pkg::S_IDLE;
      present <= '0;
      count <= '0;
      arrival <= '0;
      res_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (res_fire) res_pending <= 1'b0;
      unique case (state)
        impq_pkg::S_IDLE: if (accept) begin
          op <= operation; rid <= entry_id; rprio <= new_priority;
          res_status <= impq_pkg::ST_OK; res_id <= '0; res_prio <= '0;
          did_up <= 1'b0;
        end
        impq_pkg::S_LOOKUP: begin
          unique case (op)
            impq_pkg::OP_ENQUEUE: begin
              if (known) res_status <= impq_pkg::ST_DUPLICATE;
              else if (count == CB'(impq_pkg::CAPACITY)) res_status <= impq_pkg::ST_FULL;
              else begin
                pos <= SB'(count);
                cur <= '{id: rid, prio: rprio, seq: arrival};
                arrival <= arrival + 1'b1;
                present[rid] <= 1'b1;
                count <= count + 1'b1;
              end
            end
            impq_pkg::OP_DEQUEUE: begin
              pos <= '0;
              if (count == '0) res_status <= impq_pkg::ST_EMPTY;
            end
            default: begin
              pos <= map_rd;
              if (!known) res_status <= impq_pkg::ST_NOT_FOUND;
            end
          endcase
        end
        impq_pkg::S_READ_TOP: begin
          if (op == impq_pkg::OP_DEQUEUE) begin
            res_id <= rd_data.id; res_prio <= rd_data.prio;
          end
          if (op == impq_pkg::OP_CHANGE) begin
            cur <= '{id: rd_data.id, prio: rprio, seq: arrival};
            arrival <= arrival + 1'b1;
          end else begin
            present[rd_data.id] <= 1'b0;
            count <= count - 1'b1;
          end
        end
        impq_pkg::S_READ_LAST: if (op != impq_pkg::OP_CHANGE) cur <= rd_data;
        impq_pkg::S_UP_CMP: if (impq_pkg::ranks_before(cur, rd_data)) begin
          pos <= parent; did_up <= 1'b1;
        end
        impq_pkg::S_DN_READ_R: lft <= rd_data;
        impq_pkg::S_DN_CMP: if (pick_r) pos <= rchild;
                            else if (pick_l) pos <= lchild;
        impq_pkg::S_DONE: res_pending <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/impq_checker.sv
module impq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [7:0] out_id,
  input logic [7:0] out_priority
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= impq_pkg::ST_DUPLICATE)
    else $error("bad status code");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != impq_pkg::ST_OK |-> out_id == '0 && out_priority == '0)
    else $error("nonzero payload on failed request");

  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

endmodule

bind indexed_max_priority_queue_core impq_checker u_impq_checker (.*);
